@@ rtl/stft_pkg.sv @@
// shared types and constants for the sparse triplet transpose block
// payload structs, store entry, controller states, command and status bundles
// no dependencies
package stft_pkg;

    localparam int ROW_W = 6;
    localparam int VAL_W = 32;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef struct packed {
        logic [ROW_W-1:0]        term_row;
        logic [ROW_W-1:0]        term_col;
        logic signed [VAL_W-1:0] term_value;
        logic                    term_last;
    } t_term;

    typedef struct packed {
        logic [ROW_W-1:0]        out_row;
        logic [ROW_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    out_last;
    } t_result;

    // one stored triplet, used by both term and result stores
    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [ROW_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUSH,
        S_PREFIX,
        S_SCATTER,
        S_SDRAIN,
        S_EMIT,
        S_EDRAIN
    } t_state;

    typedef struct packed {
        logic load;
        logic prefix;
        logic scatter;
        logic emit;
        logic idx_clr;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic idx_last_col;
        logic idx_last_term;
        logic pipe_busy;
    } t_stat;

endpackage

@@ rtl/stft_ctrl.sv @@
// sequencer for the transpose: load, prefix sum, scatter, emit, clear
// drives the datapath through t_cmd and watches t_stat; uses stft_pkg
module stft_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last,
    input  stft_pkg::t_stat i_stat,
    output stft_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import stft_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_last) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                n_state = i_stat.empty ? S_IDLE : S_PREFIX;
            end
            S_PREFIX: begin
                if (i_stat.idx_last_col) n_state = S_SCATTER;
            end
            S_SCATTER: begin
                if (i_stat.idx_last_term) n_state = S_SDRAIN;
            end
            S_SDRAIN: begin
                if (!i_stat.pipe_busy) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.idx_last_term) n_state = S_EDRAIN;
            end
            S_EDRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_FLUSH: begin
                // last term's count write lands this cycle
                o_cmd.clear   = i_stat.empty;
                o_cmd.idx_clr = !i_stat.empty;
            end
            S_PREFIX: begin
                o_cmd.prefix  = 1'b1;
                o_cmd.idx_clr = i_stat.idx_last_col;
            end
            S_SCATTER: begin
                o_cmd.scatter = 1'b1;
                o_cmd.idx_clr = i_stat.idx_last_term;
            end
            S_SDRAIN: begin
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
            end
            S_EDRAIN: begin
                o_cmd.clear = 1'b1;
            end
            default: begin
            end
        endcase
    end

    a_no_scatter_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scatter |-> !i_stat.empty)
        else $error("scatter issued with no stored terms");

    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !i_stat.pipe_busy)
        else $error("emit overlaps scatter pipeline");

    a_clear_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |=> (r_state == S_IDLE))
        else $error("clear not followed by idle");

endmodule

@@ rtl/stft_dp.sv @@
// datapath: term store, column count / start slot memory, result store
// load counting, prefix sum, scatter and emit pipelines; uses stft_pkg
module stft_dp #(
    parameter int MAX_TERMS = 64,
    parameter int MAX_DIM   = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  stft_pkg::t_cmd               i_cmd,
    input  logic                         i_cfg_we,
    input  logic [stft_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  stft_pkg::t_term              i_term,
    output stft_pkg::t_stat              o_stat,
    output logic                         o_strobe,
    output stft_pkg::t_result            o_result
);
    import stft_pkg::*;

    // columns beyond the 6-bit field can never be addressed
    localparam int COL_DEPTH = (MAX_DIM < (1 << ROW_W)) ? MAX_DIM : (1 << ROW_W);
    localparam int CW   = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
    localparam int TW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNTW = $clog2(MAX_TERMS + 1);
    localparam int IW   = (CW > CNTW) ? CW : CNTW;

    logic [CFG_W-1:0] r_num_cols;
    logic [CNTW-1:0]  r_count;
    logic [IW-1:0]    r_idx;

    t_entry           term_mem [MAX_TERMS];
    t_entry           r_term_rd;
    t_entry           res_mem [MAX_TERMS];
    t_entry           r_res_rd;

    // holds column counts while loading, start slots after the prefix pass
    logic [CNTW-1:0]  col_mem [COL_DEPTH];
    logic [CNTW-1:0]  r_col_rd;
    logic [COL_DEPTH-1:0] r_col_vld;

    logic             r_lw_vld;
    logic [CW-1:0]    r_lw_addr;
    logic [CNTW-1:0]  r_lw_data;

    logic             r_ld_vld;
    logic [CW-1:0]    r_ld_col;
    logic             r_pf_vld;
    logic [CW-1:0]    r_pf_col;
    logic [CNTW-1:0]  r_run;
    logic             r_s1_vld;
    logic             r_s2_vld;
    t_entry           r_s2_entry;
    logic             r_e_vld;
    logic             r_e_last;

    logic             col_ok;
    logic             store;
    logic [CW-1:0]    cons_addr;
    logic [CW-1:0]    col_raddr;
    logic [CNTW-1:0]  cur;
    logic [CNTW-1:0]  col_wdata;
    logic             col_we;
    logic             idx_last_term;
    t_entry           ld_entry;
    t_entry           res_entry;

    assign col_ok = ({1'b0, i_term.term_col} < r_num_cols)
                 && (32'(i_term.term_col) < 32'(COL_DEPTH));
    assign store  = i_cmd.load && col_ok && (r_count != CNTW'(MAX_TERMS));

    assign idx_last_term = (r_idx + IW'(1)) == IW'(r_count);

    assign ld_entry.row   = i_term.term_row;
    assign ld_entry.col   = i_term.term_col;
    assign ld_entry.value = i_term.term_value;

    // one read-modify-write consumer of col_mem at a time
    always_comb begin
        priority if (r_ld_vld) begin
            cons_addr = r_ld_col;
        end else if (r_pf_vld) begin
            cons_addr = r_pf_col;
        end else begin
            cons_addr = r_s2_entry.col[CW-1:0];
        end
        // forward the write made at the edge that captured the read
        priority if (r_lw_vld && (r_lw_addr == cons_addr)) begin
            cur = r_lw_data;
        end else if (r_col_vld[cons_addr]) begin
            cur = r_col_rd;
        end else begin
            cur = '0;
        end
    end

    assign col_we    = r_ld_vld || r_pf_vld || r_s2_vld;
    assign col_wdata = r_pf_vld ? r_run : (cur + CNTW'(1));

    always_comb begin
        priority if (i_cmd.load) begin
            col_raddr = i_term.term_col[CW-1:0];
        end else if (i_cmd.prefix) begin
            col_raddr = r_idx[CW-1:0];
        end else begin
            col_raddr = r_term_rd.col[CW-1:0];
        end
    end

    assign res_entry.row   = r_s2_entry.col;
    assign res_entry.col   = r_s2_entry.row;
    assign res_entry.value = r_s2_entry.value;

    // memories
    always_ff @(posedge i_clk) begin
        if (store) begin
            term_mem[r_count[TW-1:0]] <= ld_entry;
        end
        r_term_rd <= term_mem[r_idx[TW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            col_mem[cons_addr] <= col_wdata;
        end
        r_col_rd <= col_mem[col_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            res_mem[cur[TW-1:0]] <= res_entry;
        end
        r_res_rd <= res_mem[r_idx[TW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_num_cols <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count   <= '0;
            r_run     <= '0;
            r_col_vld <= '0;
            r_lw_vld  <= 1'b0;
        end else begin
            if (store) begin
                r_count <= r_count + CNTW'(1);
            end
            if (r_pf_vld) begin
                r_run <= r_run + cur;
            end
            if (col_we) begin
                r_col_vld[cons_addr] <= 1'b1;
                r_lw_vld             <= 1'b1;
                r_lw_addr            <= cons_addr;
                r_lw_data            <= col_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.prefix || i_cmd.scatter || i_cmd.emit) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_vld <= 1'b0;
            r_pf_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_e_vld  <= 1'b0;
        end else begin
            r_ld_vld <= store;
            r_pf_vld <= i_cmd.prefix;
            r_s1_vld <= i_cmd.scatter;
            r_s2_vld <= r_s1_vld;
            r_e_vld  <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ld_col   <= i_term.term_col[CW-1:0];
        r_pf_col   <= r_idx[CW-1:0];
        r_s2_entry <= r_term_rd;
        r_e_last   <= idx_last_term;
    end

    assign o_stat.empty         = (r_count == '0);
    assign o_stat.idx_last_col  = (r_idx == IW'(COL_DEPTH - 1));
    assign o_stat.idx_last_term = idx_last_term;
    assign o_stat.pipe_busy     = r_s1_vld || r_s2_vld;

    assign o_strobe           = r_e_vld;
    assign o_result.out_row   = r_res_rd.row;
    assign o_result.out_col   = r_res_rd.col;
    assign o_result.out_value = r_res_rd.value;
    assign o_result.out_last  = r_e_last;

    a_one_col_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_ld_vld, r_pf_vld, r_s2_vld}))
        else $error("two writers on column memory");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> (cur < r_count))
        else $error("scatter slot beyond term count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store |-> (r_count < CNTW'(MAX_TERMS)))
        else $error("term stored into full store");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_vld && r_e_last) |=> !r_e_vld)
        else $error("result beat after final transposed term");

endmodule

@@ rtl/sparse_triplet_fast_transpose.sv @@
// sparse matrix fast transpose over (row, column, value) triplets
// terms load one per cycle while busy is low; after the last term busy stays high
// (N stored terms, D = min(MAX_DIM, 64) columns; only the flush if none are stored):
// one flush, D prefix steps, N scatter steps, a pipeline drain, N result beats, one clear
// results come one per cycle once emitting starts, set by the single result store port
// synchronous active-low reset: num_cols to 64, counts and control cleared, stores kept
module sparse_triplet_fast_transpose #(
    parameter int MAX_TERMS = 64,
    parameter int MAX_DIM   = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic [stft_pkg::CFG_W-1:0] i_cfg_wdata,
    input  stft_pkg::t_term            i_term,
    output logic                       o_strobe,
    output stft_pkg::t_result          o_result
);
    import stft_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    stft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_term.term_last),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    stft_dp #(
        .MAX_TERMS (MAX_TERMS),
        .MAX_DIM   (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_term      (i_term),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

@@ tb/tb_sparse_triplet_fast_transpose.sv @@
// testbench for sparse_triplet_fast_transpose: directed and random sparse matrices,
// checked beat by beat against a transposed-triplet predictor kept in the bench
// depends on stft_pkg and the rtl top level
`timescale 1ns / 100ps

module tb_sparse_triplet_fast_transpose;
    import stft_pkg::*;

    localparam int MAX_TERMS    = 64;
    localparam int MAX_DIM      = 64;
    // worst busy stretch after a last term, plus margin
    localparam int DRAIN_CYCLES = 2 * MAX_TERMS + MAX_DIM + 5 + 10;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic              i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;
    t_term             i_term      = '0;
    logic              o_strobe;
    t_result           o_result;

    // predictor state
    logic [CFG_W-1:0]  cols_in_use;
    t_entry            held_terms[$];
    t_result           transposed_q[$];
    int                mismatches = 0;
    int                sender_idle_pct = 0;

    sparse_triplet_fast_transpose #(
        .MAX_TERMS(MAX_TERMS),
        .MAX_DIM  (MAX_DIM)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_term     (i_term),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic int col_limit();
        return (cols_in_use < MAX_DIM) ? int'(cols_in_use) : MAX_DIM;
    endfunction

    // store the term if it fits, and on the last mark build the transposed list
    task automatic predict_term(input t_term t);
        t_entry  e;
        t_result r;
        int      n;
        int      k;
        if (int'(t.term_col) < col_limit() && held_terms.size() < MAX_TERMS) begin
            e.row   = t.term_row;
            e.col   = t.term_col;
            e.value = t.term_value;
            held_terms.push_back(e);
        end
        if (t.term_last) begin
            n = held_terms.size();
            k = 0;
            // grouped by source column, input order kept inside a column
            for (int c = 0; c < MAX_DIM; c++) begin
                foreach (held_terms[i]) begin
                    if (int'(held_terms[i].col) == c) begin
                        r.out_row   = held_terms[i].col;
                        r.out_col   = held_terms[i].row;
                        r.out_value = held_terms[i].value;
                        r.out_last  = (k == n - 1);
                        transposed_q.push_back(r);
                        k++;
                    end
                end
            end
            held_terms.delete();
        end
    endtask

    function automatic t_term make_term(input int row, input int col,
                                        input logic [VAL_W-1:0] value, input bit last);
        t_term t;
        t.term_row   = row[ROW_W-1:0];
        t.term_col   = col[ROW_W-1:0];
        t.term_value = value;
        t.term_last  = last;
        return t;
    endfunction

    // mostly in-range columns so terms get stored, some out of range
    function automatic t_term random_term(input bit last);
        int lim;
        int col;
        lim = col_limit();
        if (lim > 0 && $urandom_range(0, 99) < 85)
            col = $urandom_range(0, lim - 1);
        else
            col = $urandom_range(0, MAX_DIM - 1);
        return make_term($urandom_range(0, 63), col, $urandom, last);
    endfunction

    // start stays high after a beat unless a gap is drawn, so terms can go back to back
    task automatic send_term(input t_term t);
        int gap;
        i_term <= t;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_term(t);
        gap = 0;
        while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        while (transposed_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_num_cols(input logic [CFG_W-1:0] value);
        start <= 1'b0;
        wait_results_drained();
        // an empty matrix gives no beats but still keeps the block busy
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cols_in_use = value;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (transposed_q.size() == 0) begin
                $error("unexpected result beat: row %0d col %0d value %0d last %0b",
                       o_result.out_row, o_result.out_col, o_result.out_value,
                       o_result.out_last);
                mismatches++;
            end else begin
                if (o_result.out_row !== transposed_q[0].out_row) begin
                    $error("out_row expected %0d got %0d",
                           transposed_q[0].out_row, o_result.out_row);
                    mismatches++;
                end
                if (o_result.out_col !== transposed_q[0].out_col) begin
                    $error("out_col expected %0d got %0d",
                           transposed_q[0].out_col, o_result.out_col);
                    mismatches++;
                end
                if (o_result.out_value !== transposed_q[0].out_value) begin
                    $error("out_value expected %0d got %0d",
                           transposed_q[0].out_value, o_result.out_value);
                    mismatches++;
                end
                if (o_result.out_last !== transposed_q[0].out_last) begin
                    $error("out_last expected %0b got %0b",
                           transposed_q[0].out_last, o_result.out_last);
                    mismatches++;
                end
                void'(transposed_q.pop_front());
            end
        end
    end

    task automatic test_field_extremes();
        sender_idle_pct = 0;
        send_term(make_term(0, 0, 32'h8000_0000, 1'b0));
        send_term(make_term(63, 63, 32'h7FFF_FFFF, 1'b0));
        send_term(make_term(5, 63, 32'h0000_0000, 1'b0));
        send_term(make_term(63, 0, 32'hFFFF_FFFF, 1'b0));
        send_term(make_term(17, 5, 32'h0000_0001, 1'b1));
    endtask

    task automatic test_single_term();
        send_term(make_term(42, 21, 32'h5A5A_A5A5, 1'b1));
    endtask

    task automatic test_dropped_column();
        set_num_cols(7'd8);
        send_term(make_term(3, 8, 32'h1111_1111, 1'b0));
        send_term(make_term(9, 7, 32'h2222_2222, 1'b0));
        send_term(make_term(12, 40, 32'h3333_3333, 1'b1));
        // every term dropped, so an empty matrix
        send_term(make_term(1, 20, 32'h4444_4444, 1'b1));
    endtask

    task automatic test_zero_columns();
        set_num_cols(7'd0);
        send_term(make_term(2, 0, 32'hDEAD_BEEF, 1'b0));
        send_term(make_term(2, 1, 32'hCAFE_F00D, 1'b1));
    endtask

    task automatic test_wide_register();
        set_num_cols(7'd127);
        send_term(make_term(30, 63, 32'h0BAD_F00D, 1'b0));
        send_term(make_term(31, 0, 32'hF0F0_0F0F, 1'b1));
    endtask

    task automatic test_config_mid_matrix();
        set_num_cols(7'd64);
        send_term(make_term(4, 50, 32'h1234_5678, 1'b0));
        // stored term survives the narrower setting
        set_num_cols(7'd10);
        send_term(make_term(6, 50, 32'h8765_4321, 1'b0));
        send_term(make_term(7, 3, 32'hABCD_EF01, 1'b1));
    endtask

    task automatic test_store_full();
        int n;
        set_num_cols(7'd64);
        for (int pass = 0; pass < 2; pass++) begin
            sender_idle_pct = (pass == 0) ? 0 : 70;
            n = $urandom_range(MAX_TERMS + 1, MAX_TERMS + 8);
            for (int i = 0; i < n; i++)
                send_term(random_term(i == n - 1));
            start <= 1'b0;
            wait_results_drained();
        end
    endtask

    task automatic test_random_matrices();
        int settings[7];
        int idle_pcts[3];
        int sent;
        int quota;
        int size;
        settings  = '{64, 1, 127, 23, 0, 0, 64};
        idle_pcts = '{0, 70, 17};
        settings[5] = $urandom_range(1, 64);
        for (int p = 0; p < 7; p++) begin
            set_num_cols(settings[p][CFG_W-1:0]);
            sender_idle_pct = idle_pcts[p % 3];
            quota = (settings[p] == 0) ? 15 : 55;
            sent  = 0;
            while (sent < quota) begin
                if ($urandom_range(0, 9) == 0)
                    size = $urandom_range(13, MAX_TERMS + 8);
                else
                    size = $urandom_range(1, 12);
                for (int i = 0; i < size; i++)
                    send_term(random_term(i == size - 1));
                sent += size;
                // now and then hold off until the whole matrix is out
                if ($urandom_range(0, 4) == 0) begin
                    start <= 1'b0;
                    wait_results_drained();
                end
            end
        end
    endtask

    initial begin
        cols_in_use = CFG_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_single_term();
        test_dropped_column();
        test_zero_columns();
        test_wide_register();
        test_config_mid_matrix();
        test_store_full();
        test_random_matrices();
        start <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (transposed_q.size() != 0) begin
            $error("%0d transposed terms never came out", transposed_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/stft_pkg.sv
rtl/stft_ctrl.sv
rtl/stft_dp.sv
rtl/sparse_triplet_fast_transpose.sv
tb/tb_sparse_triplet_fast_transpose.sv
